// ----- hdl/tgb_pkg.sv -----
// ----------------------------------------------------------------------------
// tgb_pkg
// Shared constants, codes and types of the text glyph blitter.
// ----------------------------------------------------------------------------
package tgb_pkg;

   localparam int MAX_GLYPHS = 256;
   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 8;

   localparam int GLYPH_W    = $clog2(MAX_GLYPHS);
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int STORE_DEPTH = MAX_GLYPHS * MAX_ROWS;
   localparam int STORE_AW   = $clog2(STORE_DEPTH);
   localparam int HEIGHT_W   = 5;
   localparam int WIDTH_W    = 4;
   localparam int COUNT_W    = 9;
   localparam int PITCH_W    = 16;
   localparam int WORD_W     = 32;
   localparam int CURSOR_W   = 16;
   localparam int CODE_W     = 8;
   localparam int BITS_W     = 8;
   localparam int NUM_PIX    = 8;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
   localparam logic [CODE_W-1:0] CODE_LF = 8'd10;

   localparam logic [HEIGHT_W-1:0] HEIGHT_CAP =
      (MAX_ROWS > 16) ? HEIGHT_W'(16) : HEIGHT_W'(MAX_ROWS);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_CURSOR = 2'd1,
      OP_DRAW   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FONT_WIDTH  = 3'd0,
      CSR_FONT_HEIGHT = 3'd1,
      CSR_GLYPH_COUNT = 3'd2,
      CSR_LINE_PITCH  = 3'd3,
      CSR_FRAME_BASE  = 3'd4,
      CSR_FG_COLOR    = 3'd5,
      CSR_BG_COLOR    = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BASE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      ADD_ORIGIN,
      ADD_PRODUCT,
      ADD_PITCH
   } add_sel_type;

   typedef struct packed {
      logic        load_mul;
      logic        acc_en;
      add_sel_type sel;
   } addr_ctl_type;

   function automatic logic [WORD_W-1:0] pixel_color(
      input logic [BITS_W-1:0]  bits,
      input logic [WIDTH_W-1:0] width,
      input logic [WORD_W-1:0]  fg,
      input logic [WORD_W-1:0]  bg,
      input int unsigned        idx
   );
      logic [WORD_W-1:0] px;
      px = '0;
      if (idx < 32'(width)) begin
         px = bits[BITS_W-1-idx] ? fg : bg;
      end
      return px;
   endfunction

endpackage

// ----- hdl/tgb_ram.sv -----
// ----------------------------------------------------------------------------
// tgb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tgb_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tgb_addr_unit.sv -----
// ----------------------------------------------------------------------------
// tgb_addr_unit
// Shared address adder with row product register and address accumulator.
// ----------------------------------------------------------------------------
module tgb_addr_unit (
   input  logic                         clock,
   input  tgb_pkg::addr_ctl_type        ctl,
   input  logic [tgb_pkg::WORD_W-1:0]   frame_base,
   input  logic [tgb_pkg::PITCH_W-1:0]  line_pitch,
   input  logic [tgb_pkg::CURSOR_W-1:0] cursor_col,
   input  logic [tgb_pkg::CURSOR_W-1:0] cursor_row,
   output logic [tgb_pkg::WORD_W-1:0]   row_address
);
   import tgb_pkg::*;

   logic [WORD_W-1:0] mul_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] acc_in;
   logic [WORD_W-1:0] op_a;
   logic [WORD_W-1:0] op_b;

   always_comb begin
      case (ctl.sel)
         ADD_ORIGIN: begin
            op_a = frame_base;
            op_b = {{(WORD_W-CURSOR_W-2){1'b0}}, cursor_col, 2'b00};
         end
         ADD_PRODUCT: begin
            op_a = acc_ff;
            op_b = mul_ff;
         end
         ADD_PITCH: begin
            op_a = acc_ff;
            op_b = {{(WORD_W-PITCH_W){1'b0}}, line_pitch};
         end
         default: begin
            op_a = acc_ff;
            op_b = '0;
         end
      endcase
      acc_in = op_a + op_b;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         mul_ff <= WORD_W'(cursor_row) * WORD_W'(line_pitch);
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign row_address = acc_ff;

endmodule

// ----- hdl/text_glyph_blitter.sv -----
// ----------------------------------------------------------------------------
// text_glyph_blitter
// Character generator for a 32-bit-per-pixel framebuffer: loads glyph rows,
// sets the cursor, and draws characters as one result per glyph row.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   op, char_code, glyph_row,
//                                                glyph_bits, start_x, start_y
//   rsp_      out        rsp_valid / rsp_ready   row_address, pixel_count,
//                                                pixel_0..7, last_row
//   csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// Load, set cursor, carriage return, line feed and zero-height draws finish
// when accepted. A draw adds the origin when accepted, adds the row product in
// ST_BASE, then emits one row per cycle unless rsp_ready stalls, through the
// glyph store read port and shared adder, for the effective height (font_height
// capped at 16). Reset is synchronous and clears the cursor and rsp_valid;
// CSRs get defaults. Glyph store contents are undefined until loaded. An
// rsp_ready stall holds the row sequencer; req_ready is low for the draw.
// ----------------------------------------------------------------------------
module text_glyph_blitter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [tgb_pkg::CODE_W-1:0]    req_char_code,
   input  logic [3:0]                    req_glyph_row,
   input  logic [tgb_pkg::BITS_W-1:0]    req_glyph_bits,
   input  logic [11:0]                   req_start_x,
   input  logic [11:0]                   req_start_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_row_address,
   output logic [tgb_pkg::WIDTH_W-1:0]   rsp_pixel_count,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_0,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_1,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_2,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_3,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_4,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_5,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_6,
   output logic [tgb_pkg::WORD_W-1:0]    rsp_pixel_7,
   output logic                          rsp_last_row,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tgb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tgb_pkg::WORD_W-1:0]    csr_data
);
   import tgb_pkg::*;

   logic [WIDTH_W-1:0]  font_width_ff;
   logic [HEIGHT_W-1:0] font_height_ff;
   logic [COUNT_W-1:0]  glyph_count_ff;
   logic [PITCH_W-1:0]  line_pitch_ff;
   logic [WORD_W-1:0]   frame_base_ff;
   logic [WORD_W-1:0]   fg_color_ff;
   logic [WORD_W-1:0]   bg_color_ff;

   logic [CURSOR_W-1:0] cursor_col_ff;
   logic [CURSOR_W-1:0] cursor_row_ff;
   logic [CURSOR_W-1:0] cursor_col_in;
   logic [CURSOR_W-1:0] cursor_row_in;

   state_type           state_ff;
   state_type           state_in;
   logic [GLYPH_W-1:0]  glyph_ff;
   logic [GLYPH_W-1:0]  glyph_in;
   logic [HEIGHT_W-1:0] row_ff;
   logic [HEIGHT_W-1:0] row_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [WORD_W-1:0]   rsp_addr_ff;
   logic [WIDTH_W-1:0]  rsp_count_ff;
   logic [WORD_W-1:0]   rsp_pix_ff [NUM_PIX];
   logic                rsp_last_ff;

   logic [WIDTH_W-1:0]  eff_width;
   logic [HEIGHT_W-1:0] eff_height;
   logic [COUNT_W-1:0]  eff_count;
   logic                req_take;
   logic                out_free;
   logic                emit;
   logic                is_last;

   addr_ctl_type        addr_ctl;
   logic [WORD_W-1:0]   acc_address;

   logic                st_wr_en;
   logic [STORE_AW-1:0] st_wr_addr;
   logic                st_rd_en;
   logic [STORE_AW-1:0] st_rd_addr;
   logic [ROW_W-1:0]    rd_row;
   logic [BITS_W-1:0]   st_rd_data;

   always_comb begin
      eff_width = font_width_ff;
      if (font_width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (font_width_ff > WIDTH_W'(MAX_COLS)) begin
         eff_width = WIDTH_W'(MAX_COLS);
      end
      eff_height = (font_height_ff > HEIGHT_CAP) ? HEIGHT_CAP : font_height_ff;
      eff_count  = (glyph_count_ff > COUNT_W'(MAX_GLYPHS)) ? COUNT_W'(MAX_GLYPHS)
                                                          : glyph_count_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == ST_EMIT) && out_free;
   assign is_last   = ((row_ff + HEIGHT_W'(1)) == eff_height);

   always_comb begin
      state_in      = state_ff;
      glyph_in      = glyph_ff;
      row_in        = row_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      addr_ctl      = '{load_mul: 1'b0, acc_en: 1'b0, sel: ADD_ORIGIN};
      st_wr_en      = 1'b0;
      st_rd_en      = 1'b0;
      rd_row        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_op)
                  OP_LOAD: begin
                     st_wr_en = (9'(req_char_code) < 9'(MAX_GLYPHS)) &&
                                (5'(req_glyph_row) < 5'(MAX_ROWS));
                  end
                  OP_CURSOR: begin
                     cursor_col_in = CURSOR_W'(req_start_x);
                     cursor_row_in = CURSOR_W'(req_start_y);
                  end
                  OP_DRAW: begin
                     if (req_char_code == CODE_CR) begin
                        cursor_col_in = '0;
                     end else if (req_char_code == CODE_LF) begin
                        cursor_col_in = '0;
                        cursor_row_in = cursor_row_ff + CURSOR_W'(eff_height);
                     end else begin
                        cursor_col_in = cursor_col_ff + CURSOR_W'(eff_width)
                                        + CURSOR_W'(1);
                        glyph_in = (9'(req_char_code) < eff_count)
                                   ? GLYPH_W'(req_char_code) : '0;
                        row_in   = '0;
                        addr_ctl = '{load_mul: 1'b1, acc_en: 1'b1, sel: ADD_ORIGIN};
                        if (eff_height != '0) begin
                           state_in = ST_BASE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BASE: begin
            addr_ctl = '{load_mul: 1'b0, acc_en: 1'b1, sel: ADD_PRODUCT};
            st_rd_en = 1'b1;
            rd_row   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) begin
               addr_ctl = '{load_mul: 1'b0, acc_en: 1'b1, sel: ADD_PITCH};
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  st_rd_en = 1'b1;
                  rd_row   = ROW_W'(row_ff + HEIGHT_W'(1));
                  row_in   = row_ff + HEIGHT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign st_wr_addr = STORE_AW'(req_char_code) * STORE_AW'(MAX_ROWS)
                       + STORE_AW'(req_glyph_row);
   assign st_rd_addr = STORE_AW'(glyph_ff) * STORE_AW'(MAX_ROWS) + STORE_AW'(rd_row);

   tgb_ram #(
      .WIDTH (BITS_W),
      .DEPTH (STORE_DEPTH)
   ) u_glyph_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_glyph_bits),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   tgb_addr_unit u_addr_unit (
      .clock       (clock),
      .ctl         (addr_ctl),
      .frame_base  (frame_base_ff),
      .line_pitch  (line_pitch_ff),
      .cursor_col  (cursor_col_ff),
      .cursor_row  (cursor_row_ff),
      .row_address (acc_address)
   );

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         font_width_ff  <= WIDTH_W'(8);
         font_height_ff <= HEIGHT_W'(16);
         glyph_count_ff <= COUNT_W'(256);
         line_pitch_ff  <= PITCH_W'(4096);
         frame_base_ff  <= '0;
         fg_color_ff    <= '1;
         bg_color_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FONT_WIDTH:  font_width_ff  <= csr_data[WIDTH_W-1:0];
               CSR_FONT_HEIGHT: font_height_ff <= csr_data[HEIGHT_W-1:0];
               CSR_GLYPH_COUNT: glyph_count_ff <= csr_data[COUNT_W-1:0];
               CSR_LINE_PITCH:  line_pitch_ff  <= csr_data[PITCH_W-1:0];
               CSR_FRAME_BASE:  frame_base_ff  <= csr_data;
               CSR_FG_COLOR:    fg_color_ff    <= csr_data;
               CSR_BG_COLOR:    bg_color_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      row_ff   <= row_in;
      if (emit) begin
         rsp_addr_ff  <= acc_address;
         rsp_count_ff <= eff_width;
         rsp_last_ff  <= is_last;
         for (int i = 0; i < NUM_PIX; i++) begin
            rsp_pix_ff[i] <= pixel_color(st_rd_data, eff_width, fg_color_ff,
                                         bg_color_ff, i);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_address = rsp_addr_ff;
   assign rsp_pixel_count = rsp_count_ff;
   assign rsp_pixel_0     = rsp_pix_ff[0];
   assign rsp_pixel_1     = rsp_pix_ff[1];
   assign rsp_pixel_2     = rsp_pix_ff[2];
   assign rsp_pixel_3     = rsp_pix_ff[3];
   assign rsp_pixel_4     = rsp_pix_ff[4];
   assign rsp_pixel_5     = rsp_pix_ff[5];
   assign rsp_pixel_6     = rsp_pix_ff[6];
   assign rsp_pixel_7     = rsp_pix_ff[7];
   assign rsp_last_row    = rsp_last_ff;

endmodule
